/* rtl/core/fdtd1d_pkg.sv */
// shared types, codes and sizes of the 1-d fdtd yee update block
package fdtd1d_pkg;

	// sizes fixed by the item formats
	localparam int CELL_W       = 6;
	localparam int DATA_W       = 32;
	localparam int CFG_IDX_W    = 2;
	localparam int MAX_CELLS_DEF = 64;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CELLS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXCITE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAGNETIC = 2'd2;

	// configuration reset values
	localparam logic [6:0]        CELLS_RST  = 7'd64;
	localparam logic [CELL_W-1:0] EXCITE_RST = 6'd32;

	// multiplier operand select
	typedef enum logic [1:0] {
		MUL_SELF,
		MUL_CURL,
		MUL_DRIVE,
		MUL_MAG
	} mul_sel_t;

	// accumulator operation
	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_SUB
	} acc_op_t;

	// input item
	typedef struct packed {
		logic                     operation;
		logic [CELL_W-1:0]        cell_index;
		logic signed [DATA_W-1:0] self_coef;
		logic signed [DATA_W-1:0] curl_coef;
		logic signed [DATA_W-1:0] drive_coef;
		logic signed [DATA_W-1:0] source_sample;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [CELL_W-1:0]        out_cell;
		logic signed [DATA_W-1:0] e_value;
		logic                     row_last;
	} out_item_t;

	// configuration registers
	typedef struct packed {
		logic [6:0]               cells_in_use;
		logic [CELL_W-1:0]        excite_cell;
		logic signed [DATA_W-1:0] magnetic_coef;
	} cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic              tbl_wr;
		logic              src_ld;
		logic              rd_en;
		logic [CELL_W-1:0] rd_addr;
		logic [CELL_W-1:0] wr_addr;
		logic              mul_en;
		mul_sel_t          mul_sel;
		logic              dh_en;
		acc_op_t           acc_op;
		logic              head;
		logic              e_out;
		logic              e_wr;
		logic              h_wb;
		logic              last;
		logic [CELL_W-1:0] out_idx;
	} dp_cmd_t;

endpackage

/* rtl/core/fdtd_1d_yee_update.sv */
// top level of the 1-d fdtd yee leapfrog update block
//   Items enter on item when start is high and busy is low. A load item
//   (operation 0) writes the self, curl and drive coefficients of one cell
//   in that same cycle and gives no result; busy stays low.
//   A step item (operation 1) advances the grid by one time step and gives
//   one result per cell, cells 0 .. n-1 in order, each shown on result for
//   one cycle with result_valid high; row_last marks cell n-1.
//   Registers are written through cfg_we / cfg_index / cfg_wdata; the user
//   must write them only while busy is low, which the block does not enforce.
// Order of a step with n cells: cell 0 is shown first, then each interior
//   cell in turn and then cell n-1; busy falls after cell n-1 is shown.
//   The step is sequenced around the single shared 32x32 multiplier: four
//   products per interior cell (self, curl, drive and the magnetic update)
//   plus the accumulate, saturate and write-back steps.
// Reset clears the electric and magnetic fields to zero through per-entry
//   valid bits, so no clearing pass is needed; coefficients must be loaded
//   before use. The receiver cannot stall: every result is taken as shown.
module fdtd_1d_yee_update #(
	parameter int MAX_CELLS = fdtd1d_pkg::MAX_CELLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  fdtd1d_pkg::in_item_t             item,
	output logic                             result_valid,
	output fdtd1d_pkg::out_item_t            result,
	input  logic                             cfg_we,
	input  logic [fdtd1d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fdtd1d_pkg::DATA_W-1:0]    cfg_wdata
);

	fdtd1d_pkg::cfg_t    cfg;
	fdtd1d_pkg::dp_cmd_t cmd;

	// configuration registers
	fdtd1d_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// sweep sequencer
	fdtd1d_ctrl #(
		.MAX_CELLS (MAX_CELLS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (item.operation),
		.cfg       (cfg),
		.busy      (busy),
		.cmd       (cmd)
	);

	// stores and arithmetic
	fdtd1d_dpath #(
		.MAX_CELLS (MAX_CELLS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item          (item),
		.magnetic_coef (cfg.magnetic_coef),
		.result_valid  (result_valid),
		.result        (result)
	);

endmodule

/* rtl/core/fdtd1d_regs.sv */
// configuration register file of the fdtd update block
module fdtd1d_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fdtd1d_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fdtd1d_pkg::DATA_W-1:0]       cfg_wdata,
	output fdtd1d_pkg::cfg_t                    cfg
);

	fdtd1d_pkg::cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cells_in_use  <= fdtd1d_pkg::CELLS_RST;
			cfg_q.excite_cell   <= fdtd1d_pkg::EXCITE_RST;
			cfg_q.magnetic_coef <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fdtd1d_pkg::REG_CELLS: begin
					cfg_q.cells_in_use <= cfg_wdata[6:0];
				end
				fdtd1d_pkg::REG_EXCITE: begin
					cfg_q.excite_cell <= cfg_wdata[fdtd1d_pkg::CELL_W-1:0];
				end
				fdtd1d_pkg::REG_MAGNETIC: begin
					cfg_q.magnetic_coef <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/fdtd1d_ctrl.sv */
// sequencer of the fdtd sweep: walks the cells and issues datapath commands
module fdtd1d_ctrl #(
	parameter int MAX_CELLS = fdtd1d_pkg::MAX_CELLS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                operation,
	input  fdtd1d_pkg::cfg_t    cfg,
	output logic                busy,
	output fdtd1d_pkg::dp_cmd_t cmd
);

	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HEAD,
		ST_SELF,
		ST_CURL,
		ST_DRIVE,
		ST_SUM,
		ST_EOUT,
		ST_MAG,
		ST_HWB
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  x_q;
	logic [AW-1:0]  nm1_q;
	logic           last_q;

	logic [6:0]     n_cl;
	logic [AW-1:0]  x_nxt;
	logic           hit;

	// clamp the cell count into 3 .. MAX_CELLS
	always_comb begin
		if (cfg.cells_in_use < 7'd3) begin
			n_cl = 7'd3;
		end else if (cfg.cells_in_use > 7'(MAX_CELLS)) begin
			n_cl = 7'(MAX_CELLS);
		end else begin
			n_cl = cfg.cells_in_use;
		end
	end

	assign x_nxt = x_q + AW'(1);
	assign hit   = (fdtd1d_pkg::CELL_W'(x_q) == cfg.excite_cell);

	// state and cell counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			x_q     <= '0;
			nm1_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start && operation == fdtd1d_pkg::OP_STEP) begin
						x_q     <= AW'(1);
						nm1_q   <= AW'(n_cl - 7'd1);
						last_q  <= 1'b0;
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD:  state_q <= ST_SELF;
				ST_SELF:  state_q <= ST_CURL;
				ST_CURL:  state_q <= ST_DRIVE;
				ST_DRIVE: state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_EOUT;
				ST_EOUT:  state_q <= ST_MAG;
				ST_MAG:   state_q <= ST_HWB;
				ST_HWB: begin
					if (last_q) begin
						state_q <= ST_IDLE;
					end else begin
						x_q <= x_nxt;
						if (x_nxt == nm1_q) begin
							last_q  <= 1'b1;
							state_q <= ST_EOUT;
						end else begin
							state_q <= ST_SELF;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	// command decode
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = fdtd1d_pkg::MUL_SELF;
		cmd.acc_op  = fdtd1d_pkg::ACC_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (operation == fdtd1d_pkg::OP_LOAD) begin
						cmd.tbl_wr = 1'b1;
					end else begin
						cmd.src_ld  = 1'b1;
						cmd.rd_en   = 1'b1;
						cmd.rd_addr = '0;
					end
				end
			end
			ST_HEAD: begin
				cmd.head    = 1'b1;
				cmd.out_idx = '0;
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = fdtd1d_pkg::CELL_W'(x_q);
			end
			ST_SELF: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fdtd1d_pkg::MUL_SELF;
				cmd.dh_en   = 1'b1;
			end
			ST_CURL: begin
				cmd.acc_op  = fdtd1d_pkg::ACC_LOAD;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fdtd1d_pkg::MUL_CURL;
			end
			ST_DRIVE: begin
				cmd.acc_op  = fdtd1d_pkg::ACC_SUB;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fdtd1d_pkg::MUL_DRIVE;
			end
			ST_SUM: begin
				cmd.acc_op = hit ? fdtd1d_pkg::ACC_SUB : fdtd1d_pkg::ACC_HOLD;
			end
			ST_EOUT: begin
				cmd.e_out   = 1'b1;
				cmd.e_wr    = !last_q;
				cmd.wr_addr = fdtd1d_pkg::CELL_W'(x_q);
				cmd.out_idx = fdtd1d_pkg::CELL_W'(x_q);
				cmd.last    = last_q;
			end
			ST_MAG: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fdtd1d_pkg::MUL_MAG;
			end
			ST_HWB: begin
				cmd.h_wb    = 1'b1;
				cmd.wr_addr = fdtd1d_pkg::CELL_W'(x_q - AW'(1));
				if (!last_q) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = fdtd1d_pkg::CELL_W'(x_nxt);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/core/fdtd1d_dpath.sv */
// datapath of the fdtd update: field and coefficient stores, shared multiplier
module fdtd1d_dpath #(
	parameter int MAX_CELLS = fdtd1d_pkg::MAX_CELLS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fdtd1d_pkg::dp_cmd_t                cmd,
	input  fdtd1d_pkg::in_item_t               item,
	input  logic signed [fdtd1d_pkg::DATA_W-1:0] magnetic_coef,
	output logic                               result_valid,
	output fdtd1d_pkg::out_item_t              result
);

	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int DW = fdtd1d_pkg::DATA_W;
	localparam logic signed [41:0] SAT_MAX = 42'sd2147483647;
	localparam logic signed [41:0] SAT_MIN = -42'sd2147483648;

	function automatic logic signed [DW-1:0] sat32(input logic signed [41:0] v);
		if (v > SAT_MAX) begin
			return 32'sh7FFFFFFF;
		end else if (v < SAT_MIN) begin
			return 32'sh80000000;
		end
		return v[DW-1:0];
	endfunction

	// stores
	logic signed [DW-1:0] e_mem     [MAX_CELLS];
	logic signed [DW-1:0] h_mem     [MAX_CELLS];
	logic signed [DW-1:0] self_mem  [MAX_CELLS];
	logic signed [DW-1:0] curl_mem  [MAX_CELLS];
	logic signed [DW-1:0] drive_mem [MAX_CELLS];
	logic [MAX_CELLS-1:0] e_vld_q;
	logic [MAX_CELLS-1:0] h_vld_q;

	logic signed [DW-1:0] e_rd_q, h_rd_q, self_rd_q, curl_rd_q, drive_rd_q;
	logic                 e_rv_q, h_rv_q;

	logic signed [DW-1:0] src_q, e_prev_q, h_prev_q, dh_q, de_q, e_new_q;
	logic signed [63:0]   prod_s1;
	logic signed [41:0]   acc_q;
	fdtd1d_pkg::out_item_t result_q;
	logic                 valid_q;

	logic [AW-1:0]        rd_a, wr_a, ld_a;
	logic                 ld_ok;
	logic signed [DW-1:0] e_val, h_val, mul_a, mul_b, acc_sat, e_new, de, dh, h_new;
	logic signed [63:0]   rnd_full;
	logic signed [39:0]   rnd;

	assign rd_a  = cmd.rd_addr[AW-1:0];
	assign wr_a  = cmd.wr_addr[AW-1:0];
	assign ld_a  = item.cell_index[AW-1:0];
	assign ld_ok = ({1'b0, item.cell_index} < 7'(MAX_CELLS));

	// coefficient tables
	always_ff @(posedge clk) begin
		if (cmd.tbl_wr && ld_ok) begin
			self_mem[ld_a]  <= item.self_coef;
			curl_mem[ld_a]  <= item.curl_coef;
			drive_mem[ld_a] <= item.drive_coef;
		end
		if (cmd.rd_en) begin
			self_rd_q  <= self_mem[rd_a];
			curl_rd_q  <= curl_mem[rd_a];
			drive_rd_q <= drive_mem[rd_a];
		end
	end

	// field stores
	always_ff @(posedge clk) begin
		if (cmd.e_wr) begin
			e_mem[wr_a] <= e_new;
		end
		if (cmd.h_wb) begin
			h_mem[wr_a] <= h_new;
		end
		if (cmd.rd_en) begin
			e_rd_q <= e_mem[rd_a];
			h_rd_q <= h_mem[rd_a];
		end
	end

	// valid bits make never written field entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_vld_q <= '0;
			h_vld_q <= '0;
			e_rv_q  <= 1'b0;
			h_rv_q  <= 1'b0;
		end else begin
			if (cmd.e_wr) begin
				e_vld_q[wr_a] <= 1'b1;
			end
			if (cmd.h_wb) begin
				h_vld_q[wr_a] <= 1'b1;
			end
			if (cmd.rd_en) begin
				e_rv_q <= e_vld_q[rd_a];
				h_rv_q <= h_vld_q[rd_a];
			end
		end
	end

	assign e_val = e_rv_q ? e_rd_q : '0;
	assign h_val = h_rv_q ? h_rd_q : '0;

	// multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			fdtd1d_pkg::MUL_SELF: begin
				mul_a = self_rd_q;
				mul_b = e_val;
			end
			fdtd1d_pkg::MUL_CURL: begin
				mul_a = curl_rd_q;
				mul_b = dh_q;
			end
			fdtd1d_pkg::MUL_DRIVE: begin
				mul_a = drive_rd_q;
				mul_b = src_q;
			end
			fdtd1d_pkg::MUL_MAG: begin
				mul_a = magnetic_coef;
				mul_b = de_q;
			end
			default: begin
				mul_a = self_rd_q;
				mul_b = e_val;
			end
		endcase
	end

	// round half up from q24.40 to q24.16
	assign rnd_full = prod_s1 + (64'sd1 <<< 23);
	assign rnd      = rnd_full[63:24];

	assign acc_sat = sat32(acc_q);
	assign e_new   = cmd.last ? e_val : acc_sat;
	assign de      = sat32(42'(e_new) - 42'(e_prev_q));
	assign dh      = sat32(42'(h_val) - 42'(h_prev_q));
	assign h_new   = sat32(42'(h_prev_q) - 42'(rnd));

	// arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= mul_a * mul_b;
		end
		case (cmd.acc_op)
			fdtd1d_pkg::ACC_LOAD: acc_q <= 42'(rnd);
			fdtd1d_pkg::ACC_SUB:  acc_q <= acc_q - 42'(rnd);
			default: begin
			end
		endcase
		if (cmd.src_ld) begin
			src_q <= item.source_sample;
		end
		if (cmd.dh_en) begin
			dh_q <= dh;
		end
		if (cmd.head) begin
			e_prev_q <= e_val;
			h_prev_q <= h_val;
		end
		if (cmd.e_out) begin
			e_new_q <= e_new;
			de_q    <= de;
		end
		if (cmd.h_wb) begin
			e_prev_q <= e_new_q;
			h_prev_q <= h_val;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.head) begin
			result_q.out_cell <= cmd.out_idx;
			result_q.e_value  <= e_val;
			result_q.row_last <= 1'b0;
		end else if (cmd.e_out) begin
			result_q.out_cell <= cmd.out_idx;
			result_q.e_value  <= e_new;
			result_q.row_last <= cmd.last;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.head | cmd.e_out;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

/* verif/tb_top.sv */
// self-checking testbench for the 1-d fdtd yee leapfrog update block
`timescale 1ns / 1ps

module tb_top;
	import fdtd1d_pkg::*;

	localparam int  NCELLS     = MAX_CELLS_DEF;
	localparam int  QUIET_MAX  = 4000;
	localparam longint FIELD_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint FIELD_MIN = -64'sh0000_0000_8000_0000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start = 1'b0;
	logic                 busy;
	in_item_t             item = '0;
	logic                 result_valid;
	out_item_t            result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_wdata;

	fdtd_1d_yee_update #(.MAX_CELLS(NCELLS)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #10 clk = ~clk;

	// items waiting to be driven and electric cells waiting to be emitted
	in_item_t  item_q [$];
	out_item_t row_expect [$];
	int        errors = 0;
	int        quiet_cycles = 0;
	bit        gapless = 1'b0;
	int        gap_left;

	// grid state and registers as the block should hold them
	logic signed [DATA_W-1:0] e_grid    [NCELLS];
	logic signed [DATA_W-1:0] h_grid    [NCELLS];
	logic signed [DATA_W-1:0] self_tab  [NCELLS];
	logic signed [DATA_W-1:0] curl_tab  [NCELLS];
	logic signed [DATA_W-1:0] drive_tab [NCELLS];
	logic [6:0]               cur_cells  = CELLS_RST;
	logic [CELL_W-1:0]        cur_excite = EXCITE_RST;
	logic signed [DATA_W-1:0] cur_mag    = '0;

	initial begin
		for (int i = 0; i < NCELLS; i++) begin
			e_grid[i] = '0;
			h_grid[i] = '0;
			self_tab[i] = '0;
			curl_tab[i] = '0;
			drive_tab[i] = '0;
		end
	end

	// q8.24 coefficient times q16.16 field, rounded half up to q16.16
	function automatic longint round_prod(input logic signed [DATA_W-1:0] coef,
		input logic signed [DATA_W-1:0] fld);
		longint p;
		p = longint'(coef) * longint'(fld) + (longint'(1) <<< 23);
		return p >>> 24;
	endfunction

	function automatic logic signed [DATA_W-1:0] clip32(input longint v);
		if (v > FIELD_MAX)
			return 32'sh7FFF_FFFF;
		if (v < FIELD_MIN)
			return 32'sh8000_0000;
		return v[DATA_W-1:0];
	endfunction

	// one leapfrog step: electric interior, then magnetic, then emit the row
	task automatic advance_grid(input logic signed [DATA_W-1:0] src);
		int n;
		longint acc;
		logic signed [DATA_W-1:0] diff;
		out_item_t cell_out;
		n = (cur_cells < 3) ? 3 : (cur_cells > NCELLS) ? NCELLS : int'(cur_cells);
		for (int x = 1; x < n - 1; x++) begin
			diff = clip32(longint'(h_grid[x]) - longint'(h_grid[x-1]));
			acc = round_prod(self_tab[x], e_grid[x]) - round_prod(curl_tab[x], diff);
			if (x == cur_excite)
				acc -= round_prod(drive_tab[x], src);
			e_grid[x] = clip32(acc);
		end
		for (int x = 0; x < n - 1; x++) begin
			diff = clip32(longint'(e_grid[x+1]) - longint'(e_grid[x]));
			h_grid[x] = clip32(longint'(h_grid[x]) - round_prod(cur_mag, diff));
		end
		for (int x = 0; x < n; x++) begin
			cell_out.out_cell = CELL_W'(x);
			cell_out.e_value  = e_grid[x];
			cell_out.row_last = (x == n - 1);
			row_expect.push_back(cell_out);
		end
	endtask

	// mostly short gaps, a few long, none in burst phases
	function automatic int pick_gap();
		int r;
		if (gapless)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// coefficient near unit magnitude, or any 32-bit value
	function automatic logic [DATA_W-1:0] rand_coef(input bit wild);
		if (wild)
			return $urandom;
		return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
	endfunction

	// source sample within +-16.0, or any 32-bit value
	function automatic logic [DATA_W-1:0] rand_src(input bit wild);
		if (wild)
			return $urandom;
		return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
	endfunction

	task automatic push_load(input int idx, input logic [DATA_W-1:0] s,
		input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] d);
		in_item_t it;
		it.operation     = OP_LOAD;
		it.cell_index    = CELL_W'(idx);
		it.self_coef     = s;
		it.curl_coef     = c;
		it.drive_coef    = d;
		it.source_sample = $urandom;
		item_q.push_back(it);
	endtask

	task automatic push_step(input logic [DATA_W-1:0] src);
		in_item_t it;
		it.operation     = OP_STEP;
		it.cell_index    = CELL_W'($urandom_range(0, NCELLS - 1));
		it.self_coef     = $urandom;
		it.curl_coef     = $urandom;
		it.drive_coef    = $urandom;
		it.source_sample = src;
		item_q.push_back(it);
	endtask

	// hold the sender until every expected cell is out and the block is idle
	task automatic drain();
		do @(negedge clk);
		while (item_q.size() != 0 || start || busy || row_expect.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// driver: present the next item once the previous one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			item     <= '0;
			gap_left <= 0;
		end else if (!(start && busy)) begin
			if (gap_left > 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (item_q.size() > 0) begin
				start    <= 1'b1;
				item     <= item_q.pop_front();
				gap_left <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: track register writes and accepted items, check each cell
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CELLS:    cur_cells  = cfg_wdata[6:0];
					REG_EXCITE:   cur_excite = cfg_wdata[CELL_W-1:0];
					REG_MAGNETIC: cur_mag    = cfg_wdata;
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (item.operation == OP_LOAD) begin
					self_tab[item.cell_index]  = item.self_coef;
					curl_tab[item.cell_index]  = item.curl_coef;
					drive_tab[item.cell_index] = item.drive_coef;
				end else begin
					advance_grid(item.source_sample);
				end
			end
			if (result_valid) begin
				if (row_expect.size() == 0) begin
					$error("unexpected cell %0d value %h", result.out_cell, result.e_value);
					errors++;
				end else begin
					want = row_expect.pop_front();
					if (result.out_cell !== want.out_cell) begin
						$error("out_cell: expected %0d, got %0d", want.out_cell, result.out_cell);
						errors++;
					end
					if (result.e_value !== want.e_value) begin
						$error("e_value: expected %h, got %h", want.e_value, result.e_value);
						errors++;
					end
					if (result.row_last !== want.row_last) begin
						$error("row_last: expected %b, got %b", want.row_last, result.row_last);
						errors++;
					end
				end
			end
		end
	end

	// watchdog on cycles with no item, cell or register write
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int n_eff;
		int r;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// fill every coefficient entry before the first step reads any
		for (int c = 0; c < NCELLS; c++)
			push_load(c, rand_coef(0), rand_coef(0), rand_coef(0));

		// reset registers: quiet grid, then the largest source at the middle cell
		push_step('0);
		push_step(32'h7FFF_FFFF);
		drain();

		// count below three, source on the first interior cell, extreme coefficients
		write_reg(REG_CELLS, 32'd0);
		write_reg(REG_EXCITE, 32'd1);
		write_reg(REG_MAGNETIC, 32'h7FFF_FFFF);
		push_load(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		push_step(32'h8000_0000);
		push_step(32'h7FFF_FFFF);
		push_load(63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		push_load(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		drain();

		// count above the maximum, source cell past the interior
		write_reg(REG_CELLS, 32'd127);
		write_reg(REG_EXCITE, 32'd63);
		write_reg(REG_MAGNETIC, 32'h8000_0000);
		push_step(32'h1234_5678);
		drain();

		// source on end cell zero, then on the new last cell
		write_reg(REG_CELLS, 32'd2);
		write_reg(REG_EXCITE, 32'd0);
		write_reg(REG_MAGNETIC, rand_coef(0));
		push_step(rand_src(0));
		drain();
		write_reg(REG_CELLS, 32'd3);
		write_reg(REG_EXCITE, 32'd2);
		push_step(rand_src(0));
		drain();

		// full grid, source on the last interior cell, tame coefficients again
		write_reg(REG_CELLS, 32'd64);
		write_reg(REG_EXCITE, 32'd62);
		write_reg(REG_MAGNETIC, 32'h0080_0000);
		push_load(1, rand_coef(0), rand_coef(0), rand_coef(0));
		push_load(63, rand_coef(0), rand_coef(0), rand_coef(0));
		push_load(0, rand_coef(0), rand_coef(0), rand_coef(0));
		push_step(rand_src(0));
		push_step(rand_src(0));
		drain();
		write_reg(REG_CELLS, 32'd65);
		write_reg(REG_EXCITE, 32'd1);
		push_step(32'hFFF0_0000);
		drain();

		// random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				n_eff = $urandom_range(3, 12);
			else if (r < 80)
				n_eff = 64;
			else if (r < 85)
				n_eff = $urandom_range(0, 2);
			else if (r < 90)
				n_eff = $urandom_range(65, 127);
			else
				n_eff = $urandom_range(13, 63);
			write_reg(REG_CELLS, n_eff);
			n_eff = (n_eff < 3) ? 3 : (n_eff > NCELLS) ? NCELLS : n_eff;
			if ($urandom_range(0, 4) != 0)
				write_reg(REG_EXCITE, $urandom_range(1, n_eff - 2));
			else
				write_reg(REG_EXCITE, $urandom_range(0, NCELLS - 1));
			write_reg(REG_MAGNETIC, rand_coef($urandom_range(0, 6) == 0));
			gapless = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 5; k++) begin
				if ($urandom_range(0, 99) < 65)
					push_step(rand_src($urandom_range(0, 6) == 0));
				else
					push_load($urandom_range(0, NCELLS - 1),
						rand_coef($urandom_range(0, 6) == 0),
						rand_coef($urandom_range(0, 6) == 0),
						rand_coef($urandom_range(0, 6) == 0));
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
rtl/core/fdtd1d_pkg.sv
rtl/core/fdtd1d_regs.sv
rtl/core/fdtd1d_ctrl.sv
rtl/core/fdtd1d_dpath.sv
rtl/core/fdtd_1d_yee_update.sv
verif/tb_top.sv
